// ----- sv/tgbc_pkg.sv -----
package tgbc_pkg;

  localparam int MaxButtons = 16;
  localparam int CoordBits  = 12;
  localparam int IdxBits    = 4;
  localparam int DivBits    = 16;

  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  localparam logic [3:0] EV_NONE    = 4'd0;
  localparam logic [3:0] EV_ONGOING = 4'd1;
  localparam logic [3:0] EV_DOWN    = 4'd2;
  localparam logic [3:0] EV_CLICK   = 4'd3;
  localparam logic [3:0] EV_OUTSIDE = 4'd4;
  localparam logic [3:0] EV_LONG    = 4'd5;
  localparam logic [3:0] EV_REPEAT  = 4'd6;
  localparam logic [3:0] EV_STEP_R  = 4'd7;
  localparam logic [3:0] EV_STEP_L  = 4'd8;
  localparam logic [3:0] EV_STEP_D  = 4'd9;
  localparam logic [3:0] EV_STEP_U  = 4'd10;
  localparam logic [3:0] EV_END_R   = 4'd11;
  localparam logic [3:0] EV_END_L   = 4'd12;
  localparam logic [3:0] EV_END_D   = 4'd13;
  localparam logic [3:0] EV_END_U   = 4'd14;

  localparam logic [2:0] ST_NONE     = 3'd0;
  localparam logic [2:0] ST_PRESSED  = 3'd1;
  localparam logic [2:0] ST_DRAG     = 3'd2;
  localparam logic [2:0] ST_HOLD     = 3'd3;
  localparam logic [2:0] ST_RELEASED = 3'd4;

  localparam logic [2:0] CFG_ACTIVE = 3'd0;
  localparam logic [2:0] CFG_STEP   = 3'd1;
  localparam logic [2:0] CFG_LONG   = 3'd2;
  localparam logic [2:0] CFG_REPEAT = 3'd3;
  localparam logic [2:0] CFG_SMIN   = 3'd4;
  localparam logic [2:0] CFG_SW     = 3'd5;
  localparam logic [2:0] CFG_SH     = 3'd6;

  typedef logic [CoordBits-1:0] coord_t;

  typedef struct packed {
    logic   drag;
    coord_t b;
    coord_t r;
    coord_t t;
    coord_t l;
  } rect_t;

  // divider request and answer
  typedef struct packed {
    logic               start;
    logic [DivBits-1:0] num;
    logic [7:0]         den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DivBits-1:0] quo;
    logic [7:0]         rem;
  } div_rsp_t;

endpackage

// ----- sv/tgbc_ram.sv -----
module tgbc_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- sv/tgbc_div.sv -----
module tgbc_div (
  input  logic              clk,
  input  logic              rst_n,
  input  tgbc_pkg::div_req_t req,
  output tgbc_pkg::div_rsp_t rsp
);
  // restoring divider, one quotient bit a cycle
  logic [3:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [tgbc_pkg::DivBits-1:0] q_r, q_nxt;
  logic [8:0]  rem_r, rem_nxt;
  logic [7:0]  den_r, den_nxt;
  logic [8:0]  trial;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    done_nxt = 1'b0;
    trial    = {rem_r[7:0], q_r[tgbc_pkg::DivBits-1]};
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 4'(tgbc_pkg::DivBits - 1);
      q_nxt    = req.num;
      rem_nxt  = '0;
      den_nxt  = req.den;
    end else if (busy_r) begin
      q_nxt = {q_r[tgbc_pkg::DivBits-2:0], 1'b0};
      if (trial >= {1'b0, den_r}) begin
        rem_nxt  = trial - {1'b0, den_r};
        q_nxt[0] = 1'b1;
      end else begin
        rem_nxt = trial;
      end
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = q_r;
  assign rsp.rem  = rem_r[7:0];
endmodule

// ----- sv/touch_gesture_button_classifier_unit.sv -----
// Touch gesture and button classifier. Each input transaction is a sample tick,
// a button table write or a button status read, and gives exactly one result
// transaction. A moving touch tick runs two 16-bit divisions of travel by
// move_step, one bit a cycle, on a shared restoring divider. A long-press repeat
// test is a third division, of the tick count by repeat_ticks, on the same
// divider, and a button search walks the rectangle table one entry at a time
// through S_SRCH and S_SCHK, as its memory has a registered read. in_tready is
// low while a transaction is in work and while its result waits in the output
// register, so the next input is taken the cycle after the result is accepted.
module touch_gesture_button_classifier_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // action[1:0], touched[2], touch_x[14:3], touch_y[26:15], entry_index[30:27],
  // rect_left[42:31], rect_top[54:43], rect_right[66:55], rect_bottom[78:67],
  // draggable[79]
  input  logic [79:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // event_res[3:0], button_id[7:4], beep[8], button_status[11:9]
  output logic [15:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  localparam int CB = tgbc_pkg::CoordBits;
  localparam int IB = tgbc_pkg::IdxBits;
  localparam int NB = tgbc_pkg::MaxButtons;
  localparam int DB = tgbc_pkg::DivBits;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DIVX  = 4'd1;
  localparam logic [3:0] S_WX    = 4'd2;
  localparam logic [3:0] S_WY    = 4'd3;
  localparam logic [3:0] S_DECIDE= 4'd4;
  localparam logic [3:0] S_WREP  = 4'd5;
  localparam logic [3:0] S_SRCH  = 4'd6;
  localparam logic [3:0] S_SCHK  = 4'd7;
  localparam logic [3:0] S_CLR   = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;

  // search kinds
  localparam logic [1:0] K_DOWN  = 2'd0;
  localparam logic [1:0] K_CLICK = 2'd1;
  localparam logic [1:0] K_LONG  = 2'd2;
  localparam logic [1:0] K_REP   = 2'd3;

  // config
  logic [4:0]  act_r;
  logic [7:0]  mstep_r;
  logic [15:0] lpt_r;
  logic [7:0]  rpt_r;
  logic [CB-1:0] smin_r, sw_r, sh_r;

  // state
  logic [3:0]  st_r, st_nxt;
  logic [15:0] tick_r, tick_nxt;
  logic [1:0]  idle_r, idle_nxt;
  logic        tact_r, tact_nxt, slid_r, slid_nxt;
  logic [CB-1:0] spx_r, spx_nxt, spy_r, spy_nxt, cpx_r, cpx_nxt, cpy_r, cpy_nxt;
  logic [CB-1:0] slx_r, slx_nxt, sly_r, sly_nxt;
  logic [CB-1:0] lsx_r, lsx_nxt, lsy_r, lsy_nxt, sx_r, sx_nxt;
  logic [2:0]  bst_r [NB];
  logic [2:0]  bst_nxt [NB];
  logic [IB:0] idx_r, idx_nxt;
  logic [1:0]  kind_r, kind_nxt;
  logic [3:0]  ev_r, ev_nxt, id_r, id_nxt;
  logic        beep_r, beep_nxt, clrdrag_r, clrdrag_nxt;
  logic [2:0]  stat_r, stat_nxt;
  logic        ov_r, ov_nxt;
  logic [4:0]  nb;

  tgbc_pkg::div_req_t dreq;
  tgbc_pkg::div_rsp_t drsp;
  tgbc_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  logic          ram_we;
  logic [IB-1:0] ram_ra;
  tgbc_pkg::rect_t ram_wd, ram_rd;
  tgbc_ram #(.Width($bits(tgbc_pkg::rect_t)), .Depth(NB)) u_ram (
    .clk(clk), .we(ram_we), .waddr(in_tdata[30:27]), .wdata(ram_wd),
    .raddr(ram_ra), .rdata(ram_rd)
  );

  logic [1:0]    f_act;
  logic          f_touch;
  logic [CB-1:0] f_x, f_y;
  assign f_act   = in_tdata[1:0];
  assign f_touch = in_tdata[2];
  assign f_x     = in_tdata[14:3];
  assign f_y     = in_tdata[26:15];
  assign ram_wd  = {in_tdata[79], in_tdata[78:67], in_tdata[66:55], in_tdata[54:43],
                    in_tdata[42:31]};

  assign in_tready = (st_r == S_IDLE) && !ov_r;
  assign cfg_ready = 1'b1;
  assign out_tvalid = ov_r;
  assign out_tdata  = {4'd0, stat_r, beep_r, id_r, ev_r};
  assign nb = (act_r > 5'(NB)) ? 5'(NB) : act_r;
  assign ram_ra = idx_r[IB-1:0];

  logic in_acc;
  assign in_acc = in_tvalid && in_tready;

  logic [CB-1:0] mx, my, stp;
  logic in_s, in_e, hit;
  always_comb begin
    mx = (cpx_r > spx_r) ? cpx_r - spx_r : spx_r - cpx_r;
    my = (cpy_r > spy_r) ? cpy_r - spy_r : spy_r - cpy_r;
    stp = CB'(mstep_r == 8'd0 ? 8'd1 : mstep_r);
    in_s = spy_r >= ram_rd.t && spy_r <= ram_rd.b && spx_r >= ram_rd.l && spx_r <= ram_rd.r;
    in_e = cpy_r >= ram_rd.t && cpy_r <= ram_rd.b && cpx_r >= ram_rd.l && cpx_r <= ram_rd.r;
    hit  = (kind_r == K_CLICK) ? (in_s && in_e) : in_s;
  end

  always_comb begin
    st_nxt = st_r; tick_nxt = tick_r; idle_nxt = idle_r; tact_nxt = tact_r;
    slid_nxt = slid_r; spx_nxt = spx_r; spy_nxt = spy_r; cpx_nxt = cpx_r;
    cpy_nxt = cpy_r; slx_nxt = slx_r; sly_nxt = sly_r; lsx_nxt = lsx_r;
    lsy_nxt = lsy_r; sx_nxt = sx_r;
    idx_nxt = idx_r; kind_nxt = kind_r; ev_nxt = ev_r; id_nxt = id_r;
    beep_nxt = beep_r; stat_nxt = stat_r; clrdrag_nxt = clrdrag_r;
    ov_nxt = ov_r;
    for (int i = 0; i < NB; i++) bst_nxt[i] = bst_r[i];
    dreq = '0;
    ram_we = 1'b0;
    if (ov_r && out_tready) ov_nxt = 1'b0;
    case (st_r)
      S_IDLE: begin
        if (in_acc) begin
          ev_nxt = tgbc_pkg::EV_NONE; id_nxt = '0; beep_nxt = 1'b0;
          stat_nxt = tgbc_pkg::ST_NONE; idx_nxt = '0;
          st_nxt = S_OUT;
          if (f_act == tgbc_pkg::ACT_WRITE) begin
            ram_we = 1'b1;
          end else if (f_act == tgbc_pkg::ACT_READ) begin
            stat_nxt = bst_r[in_tdata[30:27]];
          end else if (f_act == tgbc_pkg::ACT_TICK) begin
            if (f_touch) begin
              if (tick_r != 16'hFFFF) tick_nxt = tick_r + 16'd1;
              if (tick_r == 16'd0) begin
                tact_nxt = 1'b1; slid_nxt = 1'b0; idle_nxt = '0;
                spx_nxt = f_x; spy_nxt = f_y; lsx_nxt = '0; lsy_nxt = '0;
                slx_nxt = f_x; sly_nxt = f_y;
                kind_nxt = K_DOWN; st_nxt = S_SRCH;
              end else begin
                cpx_nxt = f_x; cpy_nxt = f_y;
                st_nxt = S_DIVX;
              end
            end else if (tact_r) begin
              if (idle_r != 2'd3) idle_nxt = idle_r + 2'd1;
              if (idle_r >= 2'd1) begin
                tact_nxt = 1'b0; tick_nxt = '0;
                if (slid_r) begin
                  // final slide direction, end point is the current point
                  clrdrag_nxt = 1'b1; st_nxt = S_CLR;
                  if (mx > my && mx > smin_r && cpx_r > spx_r)
                    ev_nxt = tgbc_pkg::EV_END_R;
                  else if (mx > my && mx > smin_r && cpx_r < spx_r && spx_r <= sw_r)
                    ev_nxt = tgbc_pkg::EV_END_L;
                  else if (mx < my && my > smin_r && cpy_r > spy_r)
                    ev_nxt = tgbc_pkg::EV_END_D;
                  else if (mx < my && my > smin_r && cpy_r < spy_r && spy_r <= sh_r)
                    ev_nxt = tgbc_pkg::EV_END_U;
                end else begin
                  kind_nxt = K_CLICK; st_nxt = S_SRCH;
                end
              end else begin
                ev_nxt = tgbc_pkg::EV_ONGOING;
              end
            end else begin
              clrdrag_nxt = 1'b1; st_nxt = S_CLR;
            end
          end
        end
      end
      S_DIVX: begin
        dreq.start = 1'b1; dreq.num = DB'(mx); dreq.den = stp[7:0];
        st_nxt = S_WX;
      end
      S_WX: if (drsp.done) begin
        sx_nxt = drsp.quo[CB-1:0];
        dreq.start = 1'b1; dreq.num = DB'(my); dreq.den = stp[7:0];
        st_nxt = S_WY;
      end
      S_WY: if (drsp.done) begin
        st_nxt = S_DECIDE;
        lsx_nxt = sx_r; lsy_nxt = drsp.quo[CB-1:0];
        if (sx_r != lsx_r && mx > my) begin
          slid_nxt = 1'b1; slx_nxt = slx_r; clrdrag_nxt = 1'b0; st_nxt = S_CLR;
          ev_nxt = (cpx_r > slx_r) ? tgbc_pkg::EV_STEP_R :
                   (cpx_r < slx_r) ? tgbc_pkg::EV_STEP_L : tgbc_pkg::EV_NONE;
          if (cpx_r != slx_r) slx_nxt = cpx_r;
        end else if (sx_r == lsx_r && drsp.quo[CB-1:0] != lsy_r && mx < my) begin
          // a vertical step counts only when the horizontal count held still
          slid_nxt = 1'b1; clrdrag_nxt = 1'b0; st_nxt = S_CLR;
          ev_nxt = (cpy_r > sly_r) ? tgbc_pkg::EV_STEP_D :
                   (cpy_r < sly_r) ? tgbc_pkg::EV_STEP_U : tgbc_pkg::EV_NONE;
          if (cpy_r != sly_r) sly_nxt = cpy_r;
        end else if (sx_r != lsx_r || drsp.quo[CB-1:0] != lsy_r) begin
          slid_nxt = 1'b1;
        end
      end
      S_DECIDE: begin
        ev_nxt = tact_r ? tgbc_pkg::EV_ONGOING : tgbc_pkg::EV_NONE;
        st_nxt = S_OUT;
        if (tick_r >= lpt_r && !slid_r) begin
          if (tick_r == lpt_r) begin
            kind_nxt = K_LONG; st_nxt = S_SRCH;
          end else if (rpt_r != 8'd0) begin
            dreq.start = 1'b1; dreq.num = tick_r; dreq.den = rpt_r;
            st_nxt = S_WREP;
          end
        end
      end
      S_WREP: begin
        // remainder of the tick count by repeat_ticks
        if (drsp.done) begin
          st_nxt = S_OUT;
          if (drsp.rem == 8'd0) begin
            kind_nxt = K_REP; st_nxt = S_SRCH;
          end
        end
      end
      S_SRCH: begin
        // memory read of entry idx is in flight
        if (idx_r >= {1'b0, nb[IB-1:0]} && !(nb == 5'(NB) && idx_r < 5'(NB))) begin
          st_nxt = S_OUT;
          if (kind_r == K_DOWN) ev_nxt = tgbc_pkg::EV_NONE;
          else if (kind_r == K_CLICK) begin
            ev_nxt = tgbc_pkg::EV_OUTSIDE; clrdrag_nxt = 1'b1; st_nxt = S_CLR;
          end else ev_nxt = tgbc_pkg::EV_OUTSIDE;
        end else st_nxt = S_SCHK;
      end
      S_SCHK: begin
        if (hit) begin
          id_nxt = idx_r[IB-1:0]; st_nxt = S_OUT;
          case (kind_r)
            K_DOWN: begin
              ev_nxt = tgbc_pkg::EV_DOWN;
              bst_nxt[idx_r[IB-1:0]] = ram_rd.drag ? tgbc_pkg::ST_DRAG : tgbc_pkg::ST_PRESSED;
            end
            K_CLICK: begin
              ev_nxt = tgbc_pkg::EV_CLICK; beep_nxt = 1'b1;
              bst_nxt[idx_r[IB-1:0]] = tgbc_pkg::ST_RELEASED;
            end
            K_LONG: begin
              ev_nxt = tgbc_pkg::EV_LONG; bst_nxt[idx_r[IB-1:0]] = tgbc_pkg::ST_HOLD;
            end
            default: begin
              ev_nxt = tgbc_pkg::EV_REPEAT; bst_nxt[idx_r[IB-1:0]] = tgbc_pkg::ST_HOLD;
            end
          endcase
        end else begin
          idx_nxt = idx_r + 5'd1; st_nxt = S_SRCH;
        end
      end
      S_CLR: begin
        for (int i = 0; i < NB; i++) begin
          if (5'(i) < nb) begin
            if (bst_r[i] == tgbc_pkg::ST_HOLD) bst_nxt[i] = tgbc_pkg::ST_RELEASED;
            if (clrdrag_r && bst_r[i] == tgbc_pkg::ST_DRAG) bst_nxt[i] = tgbc_pkg::ST_NONE;
          end
        end
        st_nxt = S_OUT;
      end
      S_OUT: begin
        if (!ov_r || out_tready) begin
          ov_nxt = 1'b1; st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; tick_r <= '0; idle_r <= '0; tact_r <= 1'b0; slid_r <= 1'b0;
      spx_r <= '0; spy_r <= '0; cpx_r <= '0; cpy_r <= '0; slx_r <= '0; sly_r <= '0;
      lsx_r <= '0; lsy_r <= '0; ov_r <= 1'b0;
      for (int i = 0; i < NB; i++) bst_r[i] <= tgbc_pkg::ST_NONE;
      act_r <= '0; mstep_r <= 8'd20; lpt_r <= 16'd100; rpt_r <= 8'd10;
      smin_r <= CB'(32); sw_r <= CB'(240); sh_r <= CB'(320);
    end else begin
      st_r <= st_nxt; tick_r <= tick_nxt; idle_r <= idle_nxt; tact_r <= tact_nxt;
      slid_r <= slid_nxt; spx_r <= spx_nxt; spy_r <= spy_nxt; cpx_r <= cpx_nxt;
      cpy_r <= cpy_nxt; slx_r <= slx_nxt; sly_r <= sly_nxt; lsx_r <= lsx_nxt;
      lsy_r <= lsy_nxt; ov_r <= ov_nxt;
      for (int i = 0; i < NB; i++) bst_r[i] <= bst_nxt[i];
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          tgbc_pkg::CFG_ACTIVE: act_r   <= cfg_data[4:0];
          tgbc_pkg::CFG_STEP:   mstep_r <= cfg_data[7:0];
          tgbc_pkg::CFG_LONG:   lpt_r   <= cfg_data;
          tgbc_pkg::CFG_REPEAT: rpt_r   <= cfg_data[7:0];
          tgbc_pkg::CFG_SMIN:   smin_r  <= cfg_data[CB-1:0];
          tgbc_pkg::CFG_SW:     sw_r    <= cfg_data[CB-1:0];
          tgbc_pkg::CFG_SH:     sh_r    <= cfg_data[CB-1:0];
          default: ;
        endcase
      end
    end
    sx_r <= sx_nxt; idx_r <= idx_nxt;
    kind_r <= kind_nxt; ev_r <= ev_nxt; id_r <= id_nxt; beep_r <= beep_nxt;
    stat_r <= stat_nxt; clrdrag_r <= clrdrag_nxt;
  end
endmodule
